/* hdl/bed_pkg.sv */
`timescale 1ns / 1ps

package bed_pkg;

  // Characters with escape meaning
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChA         = 8'h61;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChC         = 8'h63;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChV         = 8'h76;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;

  // Decoded control characters
  localparam logic [7:0] CtlBel = 8'h07;
  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlCr  = 8'h0D;
  localparam logic [7:0] CtlHt  = 8'h09;
  localparam logic [7:0] CtlVt  = 8'h0B;
  localparam logic [7:0] CtlNul = 8'h00;

  // Result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // Results of one input item: count (0..2) and up to two bytes, in order
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } bed_res_t;

  // One queued result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } bed_item_t;

endpackage

/* hdl/bed_in_if.sv */
`timescale 1ns / 1ps

interface bed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       arg_last;

  modport source (output valid, output in_byte, output arg_last, input ready);
  modport sink (input valid, input in_byte, input arg_last, output ready);
endinterface

/* hdl/bed_out_if.sv */
`timescale 1ns / 1ps

interface bed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

/* hdl/bed_decode.sv */
`timescale 1ns / 1ps

module bed_decode #(
  parameter int unsigned MAX_OCTAL_DIGITS = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic             en_i,
  input  logic [7:0]       in_byte_i,
  input  logic             arg_last_i,
  output bed_pkg::bed_res_t res_o
);
  import bed_pkg::*;

  typedef enum logic [1:0] {
    ModeNormal,
    ModeEscape,
    ModeOctal,
    ModeDrop
  } mode_e;

  localparam logic [1:0] MaxDigits = 2'(MAX_OCTAL_DIGITS);

  mode_e      mode_q, mode_d;
  logic [7:0] oval_q, oval_d;
  logic [1:0] ocnt_q, ocnt_d;

  logic       is_digit;
  logic [7:0] oval_acc;
  logic [1:0] ocnt_inc;
  bed_res_t   res;

  assign is_digit = (in_byte_i inside {[ChZero:ChSeven]});
  // value * 8 + digit, modulo 256
  assign oval_acc = {oval_q[4:0], in_byte_i[2:0]};
  assign ocnt_inc = ocnt_q + 2'd1;

  // Next state and results for the item at the decode stage
  always_comb begin
    mode_d = mode_q;
    oval_d = oval_q;
    ocnt_d = ocnt_q;
    res    = '0;
    if (!en_i) begin
      res.cnt = 2'd1;
      res.b0  = in_byte_i;
      mode_d  = ModeNormal;
      oval_d  = '0;
      ocnt_d  = '0;
    end else begin
      case (mode_q)
        ModeNormal: begin
          if (in_byte_i == ChBackslash) begin
            mode_d = arg_last_i ? ModeNormal : ModeEscape;
          end else begin
            res.cnt = 2'd1;
            res.b0  = in_byte_i;
            mode_d  = ModeNormal;
          end
        end
        ModeEscape: begin
          mode_d  = ModeNormal;
          res.cnt = 2'd1;
          case (in_byte_i)
            ChBackslash: res.b0 = ChBackslash;
            ChA:         res.b0 = CtlBel;
            ChB:         res.b0 = CtlBs;
            ChF:         res.b0 = CtlFf;
            ChN:         res.b0 = CtlLf;
            ChR:         res.b0 = CtlCr;
            ChT:         res.b0 = CtlHt;
            ChV:         res.b0 = CtlVt;
            ChC: begin
              res.cnt = 2'd0;
              mode_d  = arg_last_i ? ModeNormal : ModeDrop;
            end
            ChZero: begin
              oval_d = '0;
              ocnt_d = '0;
              res.b0 = CtlNul;
              if (!arg_last_i) begin
                res.cnt = 2'd0;
                mode_d  = ModeOctal;
              end
            end
            default: begin
              // unknown escape: backslash, then the character
              res.cnt = 2'd2;
              res.b0  = ChBackslash;
              res.b1  = in_byte_i;
            end
          endcase
        end
        ModeOctal: begin
          if (is_digit && (ocnt_q < MaxDigits)) begin
            oval_d = oval_acc;
            ocnt_d = ocnt_inc;
            if ((ocnt_inc >= MaxDigits) || arg_last_i) begin
              res.cnt = 2'd1;
              res.b0  = oval_acc;
              oval_d  = '0;
              ocnt_d  = '0;
              mode_d  = ModeNormal;
            end
          end else begin
            // pending value first, then the byte as in normal mode
            oval_d = '0;
            ocnt_d = '0;
            res.b0 = oval_q;
            if (in_byte_i == ChBackslash) begin
              res.cnt = 2'd1;
              mode_d  = arg_last_i ? ModeNormal : ModeEscape;
            end else begin
              res.cnt = 2'd2;
              res.b1  = in_byte_i;
              mode_d  = ModeNormal;
            end
          end
        end
        ModeDrop: begin
          if (arg_last_i) begin
            mode_d = ModeNormal;
          end
        end
        default: begin
          mode_d = ModeNormal;
        end
      endcase
    end
  end

  assign res_o = res;

  // Parse state, updated on each item leaving the decode stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      oval_q <= '0;
      ocnt_q <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      oval_q <= oval_d;
      ocnt_q <= ocnt_d;
    end
  end

endmodule

/* hdl/bed_out_fifo.sv */
`timescale 1ns / 1ps

module bed_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bed_pkg::bed_res_t push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o
);
  import bed_pkg::*;

  localparam logic [FifoCntW-1:0] RoomLimit = FifoCntW'(FifoDepth - 2);

  bed_item_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic [FifoPtrW-1:0]   wr_nxt;
  logic                  pop;
  bed_item_t             head;

  assign pop    = out_valid_o && out_ready_i;
  assign wr_nxt = wr_q + FifoPtrW'(1);
  assign wr_d   = wr_q + FifoPtrW'(push_i.cnt);
  assign rd_d   = rd_q + FifoPtrW'(pop);
  assign cnt_d  = cnt_q + FifoCntW'(push_i.cnt) - FifoCntW'(pop);

  // room for the largest burst one item can push
  assign room_o      = (cnt_q <= RoomLimit);
  assign out_valid_o = (cnt_q != '0);
  assign head        = mem_q[rd_q];
  assign out_byte_o  = head.out_byte;
  assign run_last_o  = head.run_last;

  // Entry storage; the last result of an item carries the mark
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= '{out_byte: push_i.b0, run_last: (push_i.cnt == 2'd1)};
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= '{out_byte: push_i.b1, run_last: 1'b1};
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hdl/backslash_escape_decoder.sv */
`timescale 1ns / 1ps
// An input transfer is registered in the input stage, decoded and written into the result queue.
// Throughput: one input per cycle while the result queue has room; the output port moves
// one result per cycle, so an item with two results leaves them one after the other (4-entry result queue).
// Reset (rst_ni, async, active low): escapes disabled, normal parse mode,
// octal value and count cleared, input stage and result queue empty.
module backslash_escape_decoder #(
  parameter int unsigned MAX_OCTAL_DIGITS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bed_in_if.sink     in_i,
  bed_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);
  import bed_pkg::*;

  logic       esc_en_q;
  logic       in_vq;
  logic [7:0] in_byte_q;
  logic       arg_last_q;
  logic       room;
  logic       push;
  logic       in_ready;
  bed_res_t   res;
  bed_res_t   push_res;

  assign push     = in_vq && room;
  assign in_ready = !in_vq || push;
  assign in_i.ready = in_ready;

  // Escape enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      esc_en_q <= cfg_wdata_i;
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_ready) begin
      in_vq <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_byte_q  <= in_i.in_byte;
      arg_last_q <= in_i.arg_last;
    end
  end

  bed_decode #(
    .MAX_OCTAL_DIGITS (MAX_OCTAL_DIGITS)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (push),
    .en_i       (esc_en_q),
    .in_byte_i  (in_byte_q),
    .arg_last_i (arg_last_q),
    .res_o      (res)
  );

  // Only push results when the item actually moves into the queue
  always_comb begin
    push_res = res;
    if (!push) begin
      push_res.cnt = 2'd0;
    end
  end

  bed_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_res),
    .room_o      (room),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .run_last_o  (out_o.run_last)
  );

endmodule

/* hdl/bed_checker.sv */
`timescale 1ns / 1ps

module bed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [7:0] in_byte_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       run_last_i,
  input logic       cfg_we_i,
  input logic       cfg_wdata_i
);

  logic en_q;
  logic in_fire;

  assign in_fire = in_valid_i && in_ready_i;

  // Mirror of the escape enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (cfg_we_i) begin
      en_q <= cfg_wdata_i;
    end
  end

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(run_last_i))
    else $error("stalled result changed");

  // An empty output only turns valid after an input transfer has passed the input stage into the result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_fire, 2))
    else $error("result without a prior input transfer");

  // Pass-through: into an idle block, the byte comes back alone through the input stage and the result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !en_q && !out_valid_i && !$past(in_fire) |->
      ##2 (out_valid_i && run_last_i && (out_byte_i == $past(in_byte_i, 2))))
    else $error("pass-through byte lost or altered");

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_byte_i   (in_i.in_byte),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .run_last_i  (out_o.run_last),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i)
);

/* bench/backslash_escape_decoder_tb.sv */
`timescale 1ns / 1ps

module backslash_escape_decoder_tb;
  import bed_pkg::*;

  localparam int unsigned OctalDigitsMax = 3;
  localparam int unsigned SettleCycles   = 6;
  localparam int unsigned CycleLimit     = 200_000;

  // Escape letters with a defined meaning
  localparam logic [7:0] EscLetters [9] = '{ChBackslash, ChA, ChB, ChF, ChN, ChR, ChT, ChV, ChC};

  typedef enum logic [1:0] {
    PmNormal,
    PmEscape,
    PmOctal,
    PmDrop
  } parse_mode_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  bed_in_if  in_if ();
  bed_out_if out_if ();

  backslash_escape_decoder #(
    .MAX_OCTAL_DIGITS(OctalDigitsMax)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Decoder state as predicted
  logic        esc_on     = 1'b0;
  parse_mode_e mode       = PmNormal;
  logic [7:0]  oct_val    = '0;
  int unsigned oct_digits = 0;

  // Decoded bytes still owed by the block, oldest first
  bed_item_t decoded_q[$];

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned n_sent        = 0;
  int unsigned n_results     = 0;
  int unsigned n_errors      = 0;
  int unsigned cycles        = 0;

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d results still owed", $time, decoded_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output backpressure
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Compare each output transfer against the oldest owed byte
  always @(posedge clk_i) begin : check_results
    bed_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (decoded_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: got byte %h last %b", $time,
                 out_if.out_byte, out_if.run_last);
      end else begin
        want = decoded_q.pop_front();
        if (out_if.out_byte !== want.out_byte || out_if.run_last !== want.run_last) begin
          n_errors++;
          $display("%0t: mismatch: expected byte %h last %b, got byte %h last %b", $time,
                   want.out_byte, want.run_last, out_if.out_byte, out_if.run_last);
        end
      end
    end
  end

  function automatic bed_res_t append_byte(bed_res_t r, logic [7:0] b);
    if (r.cnt == 2'd0) r.b0 = b;
    else r.b1 = b;
    r.cnt = r.cnt + 2'd1;
    return r;
  endfunction

  // Byte outside any escape: a backslash opens one unless it ends the argument
  function automatic bed_res_t plain_char(bed_res_t r, logic [7:0] ch, logic last);
    if (ch == ChBackslash) begin
      mode = last ? PmNormal : PmEscape;
      return r;
    end
    mode = PmNormal;
    return append_byte(r, ch);
  endfunction

  // Advance the predicted state by one character, return the bytes it yields
  function automatic bed_res_t decode_char(logic [7:0] ch, logic last);
    bed_res_t r;
    r = '0;
    if (!esc_on) begin
      mode       = PmNormal;
      oct_val    = '0;
      oct_digits = 0;
      return append_byte(r, ch);
    end
    case (mode)
      PmNormal: r = plain_char(r, ch, last);
      PmEscape: begin
        mode = PmNormal;
        case (ch)
          ChBackslash: r = append_byte(r, ChBackslash);
          ChA:         r = append_byte(r, CtlBel);
          ChB:         r = append_byte(r, CtlBs);
          ChF:         r = append_byte(r, CtlFf);
          ChN:         r = append_byte(r, CtlLf);
          ChR:         r = append_byte(r, CtlCr);
          ChT:         r = append_byte(r, CtlHt);
          ChV:         r = append_byte(r, CtlVt);
          ChC:         mode = last ? PmNormal : PmDrop;
          ChZero: begin
            oct_val    = '0;
            oct_digits = 0;
            if (last) r = append_byte(r, CtlNul);
            else mode = PmOctal;
          end
          default: begin
            r = append_byte(r, ChBackslash);
            r = append_byte(r, ch);
          end
        endcase
      end
      PmOctal: begin
        if (ch >= ChZero && ch <= ChSeven && oct_digits < OctalDigitsMax) begin
          // value * 8 + digit, kept to 8 bits
          oct_val = {oct_val[4:0], ch[2:0]};
          oct_digits++;
          if (oct_digits >= OctalDigitsMax || last) begin
            r          = append_byte(r, oct_val);
            oct_val    = '0;
            oct_digits = 0;
            mode       = PmNormal;
          end
        end else begin
          // pending value first, then the byte as ordinary input
          r          = append_byte(r, oct_val);
          oct_val    = '0;
          oct_digits = 0;
          r          = plain_char(r, ch, last);
        end
      end
      default: if (last) mode = PmNormal;
    endcase
    return r;
  endfunction

  // One input transfer; called and returns at a falling edge
  task automatic send_char(input logic [7:0] ch, input logic last);
    bed_res_t  res;
    bed_item_t it;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.in_byte  <= ch;
    in_if.arg_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    res = decode_char(ch, last);
    if (res.cnt >= 2'd1) begin
      it.out_byte = res.b0;
      it.run_last = (res.cnt == 2'd1);
      decoded_q.push_back(it);
    end
    if (res.cnt == 2'd2) begin
      it.out_byte = res.b1;
      it.run_last = 1'b1;
      decoded_q.push_back(it);
    end
    n_sent++;
    @(negedge clk_i);
  endtask

  // Hold off input until every owed byte is out and the pipeline is empty
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_escapes(input logic en);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    esc_on = en;
  endtask

  // Random argument built mostly from well-formed escapes
  task automatic send_random_arg();
    logic [7:0]  chars[$];
    int unsigned tokens;
    int unsigned pick;
    int unsigned idx;
    tokens = $urandom_range(1, 5);
    repeat (tokens) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        chars.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 70) begin
        chars.push_back(ChBackslash);
        idx = $urandom_range(0, 9);
        if (idx < 9) chars.push_back(EscLetters[idx]);
        else chars.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 90) begin
        // octal run, digits 8 and 9 end it early
        chars.push_back(ChBackslash);
        chars.push_back(ChZero);
        repeat ($urandom_range(0, 4)) chars.push_back(8'(ChZero + $urandom_range(0, 9)));
      end else begin
        chars.push_back(ChBackslash);
      end
    end
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic test_passthrough();
    set_escapes(1'b0);
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(ChBackslash, 1'b1);
  endtask

  // Named escape, unknown escape, and the zero byte in and out of an escape
  task automatic test_named_escapes();
    set_escapes(1'b1);
    send_char(ChBackslash, 1'b0);
    send_char(ChN, 1'b0);
    send_char(ChBackslash, 1'b0);
    send_char(8'h71, 1'b0);
    send_char(ChBackslash, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(8'h00, 1'b1);
  endtask

  // Full run wrapping past 255, run cut by a non-digit, and \0 at the end
  task automatic test_octal_runs();
    send_char(ChBackslash, 1'b0);
    send_char(ChZero, 1'b0);
    send_char(ChSeven, 1'b0);
    send_char(ChSeven, 1'b0);
    send_char(ChSeven, 1'b1);
    send_char(ChBackslash, 1'b0);
    send_char(ChZero, 1'b0);
    send_char(ChSeven, 1'b0);
    send_char(8'h78, 1'b1);
    send_char(ChBackslash, 1'b0);
    send_char(ChZero, 1'b1);
  endtask

  task automatic test_drop_and_trailing();
    send_char(ChBackslash, 1'b0);
    send_char(ChC, 1'b0);
    send_char(8'h7A, 1'b1);
    send_char(ChBackslash, 1'b1);
  endtask

  // Pause with a half-parsed argument, including a switch to passthrough
  task automatic test_pause_mid_argument();
    set_escapes(1'b1);
    send_char(ChBackslash, 1'b0);
    send_char(ChZero, 1'b0);
    send_char(8'h35, 1'b0);
    set_escapes(1'b0);
    send_char(8'h41, 1'b1);
    set_escapes(1'b1);
    send_char(ChBackslash, 1'b0);
    wait_idle();
    send_char(ChN, 1'b1);
    send_char(8'h33, 1'b1);
  endtask

  task automatic test_random_args(input int unsigned count);
    int unsigned target;
    target = n_sent + count;
    while (n_sent < target) send_random_arg();
  endtask

  task automatic test_random_bytes(input int unsigned count);
    repeat (count) send_char(8'($urandom_range(1, 255)), 1'($urandom_range(1)));
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_byte  = '0;
    in_if.arg_last = 1'b0;
    out_if.ready   = 1'b0;
    // reset held, then released at a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct  = 8;
    sink_idle_pct = 77;
    test_passthrough();
    test_named_escapes();
    test_octal_runs();
    test_drop_and_trailing();
    test_random_args(140);

    src_idle_pct  = 77;
    sink_idle_pct = 8;
    test_pause_mid_argument();
    set_escapes(1'b0);
    test_random_bytes(40);
    set_escapes(1'b1);
    test_random_bytes(30);
    test_random_args(90);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_args(110);

    wait_idle();
    n_errors += decoded_q.size();
    $display("Covered %0d input transfers and %0d decoded bytes with escapes on and off,",
             n_sent, n_results);
    $display("under input gaps, output stalls, full rate and a mid-argument pause.");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bed_pkg.sv
hdl/bed_in_if.sv
hdl/bed_out_if.sv
hdl/bed_decode.sv
hdl/bed_out_fifo.sv
hdl/backslash_escape_decoder.sv
hdl/bed_checker.sv
bench/backslash_escape_decoder_tb.sv
